/* hdl/three_byte_sequence_finder_core_defines.svh */
// Assertion macros shared by the finder RTL.
`ifndef THREE_BYTE_SEQUENCE_FINDER_CORE_DEFINES_SVH
`define THREE_BYTE_SEQUENCE_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TBSF_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tbsf: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define TBSF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tbsf: next-cycle check failed");

`endif

/* hdl/tbsf_pkg.sv */
`default_nettype none

package tbsf_pkg;

    localparam int BEAT_W      = 64;
    localparam int BEAT_LANES  = 8;
    localparam int COUNT_W     = 4;
    localparam int OFFSET_OUT_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_BYTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_BYTE  = 2'd2;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } pattern_t;

    typedef struct packed {
        logic                    found;
        logic [OFFSET_OUT_W-1:0] match_offset;
    } result_t;

endpackage

`default_nettype wire

/* hdl/tbsf_lane.sv */
`default_nettype none

// One compare lane: does the three-byte window ending at this lane match.
module tbsf_lane
(
    input  wire logic              lane_en,
    input  wire logic [7:0]        older_byte,
    input  wire logic [7:0]        newer_byte,
    input  wire logic [7:0]        cur_byte,
    input  wire tbsf_pkg::pattern_t pattern,
    output logic                   hit
);

    assign hit = lane_en
               && (older_byte == pattern.first_byte)
               && (newer_byte == pattern.second_byte)
               && (cur_byte   == pattern.third_byte);

endmodule

`default_nettype wire

/* hdl/tbsf_merge.sv */
`default_nettype none

// Picks the earliest lane hit and turns it into a saturated start offset.
module tbsf_merge
#(
    parameter int BYTES_PER_BEAT = 8,
    parameter int OFFSET_BITS    = 32
)
(
    input  wire logic [BYTES_PER_BEAT-1:0] lane_hit,
    input  wire logic                      match_seen,
    input  wire logic [OFFSET_BITS-1:0]    byte_position,
    output logic                           new_hit,
    output logic [OFFSET_BITS-1:0]         new_offset
);

    localparam int IDX_W = $clog2(BYTES_PER_BEAT + 1);

    logic [IDX_W-1:0]       hit_idx;
    logic [OFFSET_BITS:0]   pos_sum;
    logic [OFFSET_BITS-1:0] third_pos;

    // lowest lane wins
    always_comb
    begin
        hit_idx = '0;
        for (int k = BYTES_PER_BEAT - 1; k >= 0; k--)
        begin
            if (lane_hit[k])
            begin
                hit_idx = IDX_W'(k);
            end
        end
    end

    assign new_hit = (|lane_hit) && !match_seen;

    // position of the third byte, held at the top of the range
    assign pos_sum    = {1'b0, byte_position} + (OFFSET_BITS + 1)'(hit_idx);
    assign third_pos  = pos_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}}
                                             : pos_sum[OFFSET_BITS-1:0];
    assign new_offset = third_pos - OFFSET_BITS'(2);

endmodule

`default_nettype wire

/* hdl/tbsf_out_buf.sv */
`default_nettype none

`include "three_byte_sequence_finder_core_defines.svh"

// Output register plus one skid entry; busy only when both are held.
module tbsf_out_buf
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tbsf_pkg::result_t push_data,
    output logic                   busy,
    output logic                   out_valid,
    output tbsf_pkg::result_t      out_data,
    input  wire logic              out_stall
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    tbsf_pkg::result_t out_data_reg, out_data_next;
    tbsf_pkg::result_t skid_data_reg, skid_data_next;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign busy      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `TBSF_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `TBSF_ASSERT_NEXT(a_held_beat_kept, clk, rst_n, out_valid_reg && out_stall, out_valid_reg)

endmodule

`default_nettype wire

/* hdl/three_byte_sequence_finder_core.sv */
`default_nettype none

`include "three_byte_sequence_finder_core_defines.svh"

// Three-byte pattern finder. Scans a byte string that arrives as beats of up to
// BYTES_PER_BEAT bytes (earliest byte in beat_bytes[7:0], valid_count bytes used
// from the low end, last_beat closing the string) for the first place where
// first_byte, second_byte, third_byte occur in order, including matches that
// straddle beats. One beat is taken every cycle while in_stall is low: every
// lane compares its window at once and the merge picks the earliest hit, so the
// position and history update is the only loop. Beats without last_beat give
// no result; a last beat gives one result (found, match_offset), registered
// into the output register, or into the skid entry when an older result waits.
// match_offset is the start of the first match and zero when nothing was found;
// strings shorter than three bytes give not found. The position saturates at
// 2^OFFSET_BITS-1. A two-entry output buffer lets beats keep flowing while a
// result waits; in_stall rises only when both entries hold results. Pattern
// registers are written through cfg_we, cfg_index, cfg_wdata and should change only between strings.
module three_byte_sequence_finder_core
#(
    parameter int BYTES_PER_BEAT = 8,
    parameter int OFFSET_BITS    = 32
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [tbsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tbsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input beats
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [tbsf_pkg::BEAT_W-1:0]         beat_bytes,
    input  wire logic [tbsf_pkg::COUNT_W-1:0]        valid_count,
    input  wire logic                                last_beat,
    // results
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     found,
    output logic [tbsf_pkg::OFFSET_OUT_W-1:0]        match_offset
);

    localparam int CNT_W = $clog2(BYTES_PER_BEAT + 1);

    // pattern registers
    tbsf_pkg::pattern_t pattern_reg;

    // search state
    logic [15:0]            history_reg, history_next;
    logic [1:0]             hist_count_reg, hist_count_next;
    logic [OFFSET_BITS-1:0] position_reg, position_next;
    logic                   match_seen_reg, match_seen_next;
    logic [OFFSET_BITS-1:0] first_off_reg, first_off_next;

    logic                      in_fire;
    logic                      buf_busy;
    logic [CNT_W-1:0]          count_sat;
    logic [7:0]                ext_byte [BYTES_PER_BEAT+2];
    logic [BYTES_PER_BEAT-1:0] lane_en;
    logic [BYTES_PER_BEAT-1:0] lane_hit;
    logic                      new_hit;
    logic [OFFSET_BITS-1:0]    new_offset;
    logic [CNT_W:0]            hist_sum;
    logic [OFFSET_BITS:0]      pos_sum;
    logic [OFFSET_BITS-1:0]    off_full;
    tbsf_pkg::result_t         res;
    tbsf_pkg::result_t         out_res;

    assign in_fire  = in_valid && !buf_busy;
    assign in_stall = buf_busy;

    // counts above the lane count are clipped
    always_comb
    begin
        if ({1'b0, valid_count} > (tbsf_pkg::COUNT_W + 1)'(BYTES_PER_BEAT))
        begin
            count_sat = CNT_W'(BYTES_PER_BEAT);
        end
        else
        begin
            count_sat = CNT_W'(valid_count);
        end
    end

    // carried window: two history bytes, then this beat's lanes
    assign ext_byte[0] = history_reg[15:8];
    assign ext_byte[1] = history_reg[7:0];

    for (genvar k = 0; k < BYTES_PER_BEAT; k++)
    begin : g_lane
        localparam int NEED = (k >= 2) ? 0 : (2 - k);

        // lanes beyond the physical beat read as zero bytes
        if (k < tbsf_pkg::BEAT_LANES)
        begin : g_byte
            assign ext_byte[k+2] = beat_bytes[8*k +: 8];
        end
        else
        begin : g_zero
            assign ext_byte[k+2] = 8'h00;
        end

        // a window counts only if all three of its bytes exist
        assign lane_en[k] = (CNT_W'(k) < count_sat) && (hist_count_reg >= 2'(NEED));

        tbsf_lane u_lane
        (
            .lane_en    (lane_en[k]),
            .older_byte (ext_byte[k]),
            .newer_byte (ext_byte[k+1]),
            .cur_byte   (ext_byte[k+2]),
            .pattern    (pattern_reg),
            .hit        (lane_hit[k])
        );
    end

    tbsf_merge
    #(
        .BYTES_PER_BEAT (BYTES_PER_BEAT),
        .OFFSET_BITS    (OFFSET_BITS)
    )
    u_merge
    (
        .lane_hit      (lane_hit),
        .match_seen    (match_seen_reg),
        .byte_position (position_reg),
        .new_hit       (new_hit),
        .new_offset    (new_offset)
    );

    assign hist_sum = (CNT_W + 1)'(hist_count_reg) + (CNT_W + 1)'(count_sat);
    assign pos_sum  = {1'b0, position_reg} + (OFFSET_BITS + 1)'(count_sat);

    // next search state
    always_comb
    begin
        history_next = history_reg;
        for (int j = 0; j <= BYTES_PER_BEAT; j++)
        begin
            if (count_sat == CNT_W'(j))
            begin
                history_next = {ext_byte[j], ext_byte[j+1]};
            end
        end

        hist_count_next = (hist_sum >= (CNT_W + 1)'(2)) ? 2'd2 : hist_sum[1:0];
        position_next   = pos_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}}
                                               : pos_sum[OFFSET_BITS-1:0];
        match_seen_next = match_seen_reg || new_hit;
        first_off_next  = new_hit ? new_offset : first_off_reg;

        // string closed: start over
        if (last_beat)
        begin
            history_next    = '0;
            hist_count_next = '0;
            position_next   = '0;
            match_seen_next = 1'b0;
            first_off_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg    <= '0;
            history_reg    <= '0;
            hist_count_reg <= '0;
            position_reg   <= '0;
            match_seen_reg <= 1'b0;
            first_off_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tbsf_pkg::REG_FIRST_BYTE:  pattern_reg.first_byte  <= cfg_wdata;
                    tbsf_pkg::REG_SECOND_BYTE: pattern_reg.second_byte <= cfg_wdata;
                    tbsf_pkg::REG_THIRD_BYTE:  pattern_reg.third_byte  <= cfg_wdata;
                    default:                   ; // unmapped index: dropped
                endcase
            end
            if (in_fire)
            begin
                history_reg    <= history_next;
                hist_count_reg <= hist_count_next;
                position_reg   <= position_next;
                match_seen_reg <= match_seen_next;
                first_off_reg  <= first_off_next;
            end
        end
    end

    // result of the closing beat
    assign off_full = match_seen_reg ? first_off_reg
                    : (new_hit ? new_offset : '0);

    if (OFFSET_BITS >= tbsf_pkg::OFFSET_OUT_W)
    begin : g_off_trunc
        assign res.match_offset = off_full[tbsf_pkg::OFFSET_OUT_W-1:0];
    end
    else
    begin : g_off_ext
        assign res.match_offset = {{(tbsf_pkg::OFFSET_OUT_W - OFFSET_BITS){1'b0}}, off_full};
    end

    assign res.found = match_seen_reg || new_hit;

    tbsf_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire && last_beat),
        .push_data (res),
        .busy      (buf_busy),
        .out_valid (out_valid),
        .out_data  (out_res),
        .out_stall (out_stall)
    );

    assign found        = out_res.found;
    assign match_offset = out_res.match_offset;

    `TBSF_ASSERT_IMPL(a_hist_count_range, clk, rst_n, 1'b1, hist_count_reg != 2'd3)
    `TBSF_ASSERT_NEXT(a_last_clears_search, clk, rst_n, in_fire && last_beat, !match_seen_reg && (position_reg == '0))
    `TBSF_ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_fire && last_beat, out_valid)
    `TBSF_ASSERT_IMPL(a_not_found_zero_offset, clk, rst_n, out_valid && !found, match_offset == '0)

endmodule

`default_nettype wire

/* verif/three_byte_sequence_finder_core_test.sv */
`default_nettype none

module three_byte_sequence_finder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog: cycles in a row with no beat moving on either channel
    localparam int STALL_LIMIT     = 2000;
    // Beats with bytes or a last flag per random phase, about 500 over the three phases
    localparam int BEATS_PER_PHASE = 165;
    // Spare cycles waited once all expected results are taken
    localparam int DRAIN_CYCLES    = 4;
    localparam int TAIL_CYCLES     = 8;
    // Index 3 maps to no register; writes to it must leave the pattern alone
    localparam logic [tbsf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [tbsf_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [tbsf_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [tbsf_pkg::BEAT_W-1:0]       beat_bytes = '0;
    logic [tbsf_pkg::COUNT_W-1:0]      valid_count = '0;
    logic                              last_beat = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic                              found;
    logic [tbsf_pkg::OFFSET_OUT_W-1:0] match_offset;

    // Idle rates, in percent per cycle, for the sender and the receiver
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Predictor state: pattern copy plus the search state carried across beats
    tbsf_pkg::pattern_t pat = '0;
    logic [15:0]        hist_bytes = '0;
    int                 hist_cnt = 0;
    logic [31:0]        next_pos = '0;
    logic               hit_seen = 1'b0;
    logic [31:0]        hit_offset = '0;

    tbsf_pkg::result_t expected_results[$];

    int error_count     = 0;
    int beats_sent      = 0;
    int strings_sent    = 0;
    int results_checked = 0;
    int hits_checked    = 0;
    int idle_cycles     = 0;

    three_byte_sequence_finder_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .beat_bytes   (beat_bytes),
        .valid_count  (valid_count),
        .last_beat    (last_beat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .match_offset (match_offset)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic void clear_search();
        hist_bytes = '0;
        hist_cnt   = 0;
        next_pos   = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;
    endfunction

    // One string byte: compare the window ending here, then shift it into history.
    // Position saturates at all ones.
    function automatic void absorb_byte(input logic [7:0] b);
        if (!hit_seen && hist_cnt >= 2 && hist_bytes[15:8] == pat.first_byte &&
            hist_bytes[7:0] == pat.second_byte && b == pat.third_byte)
        begin
            hit_seen   = 1'b1;
            hit_offset = next_pos - 32'd2;
        end
        hist_bytes = {hist_bytes[7:0], b};
        if (hist_cnt < 2)
            hist_cnt++;
        if (next_pos != '1)
            next_pos++;
    endfunction

    // Counts above the lane count saturate; only the last beat yields a result
    function automatic void predict_beat(input logic [tbsf_pkg::BEAT_W-1:0] data,
                                         input logic [tbsf_pkg::COUNT_W-1:0] cnt,
                                         input logic last);
        int                lanes;
        tbsf_pkg::result_t want;
        lanes = (cnt > tbsf_pkg::BEAT_LANES) ? tbsf_pkg::BEAT_LANES : int'(cnt);
        for (int k = 0; k < lanes; k++)
            absorb_byte(data[8*k +: 8]);
        if (last)
        begin
            want.found        = hit_seen;
            want.match_offset = hit_seen ? hit_offset : '0;
            expected_results.push_back(want);
            clear_search();
        end
    endfunction

    function automatic void note_write(input logic [tbsf_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [tbsf_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            tbsf_pkg::REG_FIRST_BYTE:  pat.first_byte  = val;
            tbsf_pkg::REG_SECOND_BYTE: pat.second_byte = val;
            tbsf_pkg::REG_THIRD_BYTE:  pat.third_byte  = val;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Caller lowers cfg_we after its last write
    task automatic write_reg(input logic [tbsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbsf_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        note_write(idx, val);
    endtask

    task automatic set_pattern(input tbsf_pkg::pattern_t p);
        write_reg(tbsf_pkg::REG_FIRST_BYTE, p.first_byte);
        write_reg(tbsf_pkg::REG_SECOND_BYTE, p.second_byte);
        write_reg(tbsf_pkg::REG_THIRD_BYTE, p.third_byte);
        cfg_we <= 1'b0;
    endtask

    // One beat. Valid stays high into the next call unless that call idles first,
    // so valid is never dropped and raised within one step.
    task automatic send_beat(input logic [tbsf_pkg::BEAT_W-1:0] data,
                             input logic [tbsf_pkg::COUNT_W-1:0] cnt,
                             input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        beat_bytes  <= data;
        valid_count <= cnt;
        last_beat   <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_beat(data, cnt, last);
        if (cnt != 0 || last)
            beats_sent++;
        if (last)
            strings_sent++;
    endtask

    // Wait until every result is in, then let the output register settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Biased toward pattern bytes so partial and full matches are common
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 4))
            0: return pat.first_byte;
            1: return pat.second_byte;
            2: return pat.third_byte;
            default: return 8'($urandom);
        endcase
    endfunction

    // A random string chopped into beats of random size. Some beats carry no
    // bytes, full beats sometimes claim more than eight, and some strings end
    // on an empty last beat. Lanes past the count hold junk.
    task automatic send_string();
        logic [7:0]                   str[$];
        int                           len;
        int                           idx;
        int                           n;
        int                           room;
        int                           spot;
        int                           roll;
        bit                           empty_tail;
        logic [tbsf_pkg::BEAT_W-1:0]  data;
        logic [tbsf_pkg::COUNT_W-1:0] cnt;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 40);
        for (int i = 0; i < len; i++)
            str.push_back(pick_byte());
        if (len >= 3 && $urandom_range(0, 99) < 60)
        begin
            spot = $urandom_range(0, len - 3);
            str[spot]     = pat.first_byte;
            str[spot + 1] = pat.second_byte;
            str[spot + 2] = pat.third_byte;
        end
        empty_tail = (len == 0) || ($urandom_range(0, 9) == 0);
        idx = 0;
        while (idx < len)
        begin
            room = (len - idx < tbsf_pkg::BEAT_LANES) ? len - idx : tbsf_pkg::BEAT_LANES;
            roll = $urandom_range(0, 99);
            if (roll < 6)
                n = 0;
            else if (roll < 55)
                n = room;
            else
                n = $urandom_range(1, room);
            data = {$urandom, $urandom};
            for (int k = 0; k < n; k++)
                data[8*k +: 8] = str[idx + k];
            cnt = tbsf_pkg::COUNT_W'(n);
            if (n == tbsf_pkg::BEAT_LANES && $urandom_range(0, 4) == 0)
                cnt = tbsf_pkg::COUNT_W'($urandom_range(tbsf_pkg::BEAT_LANES + 1, 15));
            idx += n;
            send_beat(data, cnt, (n != 0) && (idx == len) && !empty_tail);
        end
        if (empty_tail)
            send_beat({$urandom, $urandom}, '0, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        tbsf_pkg::result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected, found", 32'(found), '0);
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.found)
                    hits_checked++;
                if (found !== want.found)
                    report_mismatch("found", 32'(found), 32'(want.found));
                if (match_offset !== want.match_offset)
                    report_mismatch("match_offset", match_offset, want.match_offset);
            end
        end
    end

    // Ends the run if nothing moves for too long
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Pattern resets to three zero bytes
    task automatic test_reset_pattern();
        send_beat(64'h0000_0000_0000_0000, 4'd8, 1'b1);
    endtask

    // Pattern FF 00 80: short strings, straddles, empty and oversized counts
    task automatic test_pattern_positions();
        wait_idle();
        set_pattern(tbsf_pkg::pattern_t'({8'hFF, 8'h00, 8'h80}));
        // short strings; junk past the count must not complete a match
        send_beat(64'h1234_5678_9A80_00FF, 4'd1, 1'b1);
        send_beat(64'hDEAD_BEEF_0080_00FF, 4'd2, 1'b1);
        send_beat(64'h0000_0000_0080_00FF, 4'd3, 1'b1);
        // match split two bytes then one across beats
        send_beat(64'h00FF_1122_3344_5566, 4'd8, 1'b0);
        send_beat(64'h0000_0000_0000_0080, 4'd1, 1'b1);
        // match split one byte then two
        send_beat(64'hFF11_2233_4455_6677, 4'd8, 1'b0);
        send_beat(64'h0000_0000_0000_8000, 4'd2, 1'b1);
        // empty beat in the middle of a straddled match
        send_beat(64'hAA00_FF11_2233_4455, 4'd7, 1'b0);
        send_beat(64'h0000_0000_0000_0080, 4'd0, 1'b0);
        send_beat(64'h0000_0000_0000_0080, 4'd1, 1'b1);
        // empty string: a lone last beat with no bytes
        send_beat(64'h0000_0000_0080_00FF, 4'd0, 1'b1);
        // counts above eight saturate
        send_beat(64'h8000_FF00_0000_0000, 4'd15, 1'b1);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1);
        // two matches in one beat: the first wins
        send_beat(64'h8000_FF80_00FF_1111, 4'd8, 1'b1);
        // offset carried past the first beat
        send_beat(64'h1111_1111_1111_1111, 4'd8, 1'b0);
        send_beat(64'h0000_0000_0080_00FF, 4'd8, 1'b1);
    endtask

    // Self-overlapping pattern; history must not leak across strings
    task automatic test_repeated_byte_pattern();
        wait_idle();
        set_pattern(tbsf_pkg::pattern_t'({8'hAA, 8'hAA, 8'hAA}));
        send_beat(64'h0000_0000_AAAA_AAAA, 4'd4, 1'b1);
        send_beat(64'h0000_0000_0000_AAAA, 4'd2, 1'b0);
        send_beat(64'h0000_0000_0000_00AA, 4'd1, 1'b1);
        send_beat(64'h0000_0000_0000_AAAA, 4'd2, 1'b1);
        send_beat(64'h0000_0000_0000_00AA, 4'd1, 1'b1);
    endtask

    // A write to the unused index changes nothing
    task automatic test_unused_index();
        wait_idle();
        write_reg(REG_UNUSED, 8'h00);
        cfg_we <= 1'b0;
        send_beat(64'h0000_0000_00AA_AAAA, 4'd3, 1'b1);
    endtask

    // The stray write goes first so cfg_we is lowered once, after the pattern
    task automatic test_random_strings(input int send_pct, input int stall_pct,
                                       input tbsf_pkg::pattern_t p, input bit stray_write);
        int start_beats;
        wait_idle();
        if (stray_write)
            write_reg(REG_UNUSED, 8'($urandom));
        set_pattern(p);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start_beats    = beats_sent;
        while (beats_sent - start_beats < BEATS_PER_PHASE)
            send_string();
    endtask

    initial
    begin
        // Single reset at the start of the run
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 35;
        recv_stall_pct = 61;
        test_reset_pattern();
        test_pattern_positions();
        test_repeated_byte_pattern();
        test_unused_index();

        // Random phases: receiver-heavy stalls, sender-heavy idling, then none
        test_random_strings(35, 61, tbsf_pkg::pattern_t'({8'h00, 8'hFF, 8'h00}), 1'b0);
        test_random_strings(61, 35, tbsf_pkg::pattern_t'(24'($urandom)), 1'b1);
        test_random_strings(0, 0, tbsf_pkg::pattern_t'({8'hFF, 8'hFF, 8'hFF}), 1'b0);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d strings in %0d beats: straddled, short, empty and oversized beats.",
                 strings_sent, beats_sent);
        $display("%0d results checked, %0d with a match, %0d mismatches.",
                 results_checked, hits_checked, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
